// File: rtl/lprl_pkg.sv
// Package for the light pulse run-length decoder: widths, reset values,
// register codes and the sample class type shared by all blocks.
// No dependencies.
package lprl_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int THR_W      = 12;
  localparam int TOL_W      = 8;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam int FRAME_LEN  = 12;
  localparam int COUNT_BITS = 16;
  localparam int POS_W      = $clog2(FRAME_LEN + 1);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [THR_W-1:0] LOW_THR_RST  = THR_W'(117);
  localparam logic [THR_W-1:0] HIGH_THR_RST = THR_W'(651);
  localparam logic [TOL_W-1:0] RUN_TOL_RST  = TOL_W'(15);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THR  = 2'd0,
    CFG_HIGH_THR = 2'd1,
    CFG_RUN_TOL  = 2'd2
  } cfg_reg_e;

  // Classification of one sample: both flags may be set when the
  // thresholds overlap.
  typedef struct packed {
    logic dark;
    logic lit;
  } sample_class_t;

endpackage

// File: rtl/lprl_if.sv
// Handshake interfaces of the light pulse run-length decoder: sample input,
// frame output and configuration write channel.
// Depends on lprl_pkg.
interface lprl_sample_if;
  logic                          valid;
  logic                          ready;
  logic [lprl_pkg::SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface lprl_frame_if;
  logic                           valid;
  logic                           ready;
  logic [lprl_pkg::FRAME_LEN-1:0] frame_bits;

  modport source (output valid, output frame_bits, input ready);
  modport sink   (input valid, input frame_bits, output ready);
endinterface

interface lprl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lprl_pkg::CFG_IDX_W-1:0]  index;
  logic [lprl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/lprl_front.sv
// Front end: holds the configuration registers and sorts each accepted
// sample into dark and lit classes for the queue.
// Depends on lprl_pkg and lprl_if.
module lprl_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lprl_sample_if.sink                   sample_i,
  lprl_cfg_if.sink                      cfg_i,
  input  logic                          q_ready_i,
  output logic                          q_push_o,
  output lprl_pkg::sample_class_t       q_data_o,
  output logic [lprl_pkg::TOL_W-1:0]    run_tol_o
);

  logic [lprl_pkg::THR_W-1:0] low_thr_q, low_thr_d;
  logic [lprl_pkg::THR_W-1:0] high_thr_q, high_thr_d;
  logic [lprl_pkg::TOL_W-1:0] run_tol_q, run_tol_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    low_thr_d  = low_thr_q;
    high_thr_d = high_thr_q;
    run_tol_d  = run_tol_q;
    if (cfg_i.valid) begin
      case (lprl_pkg::cfg_reg_e'(cfg_i.index))
        lprl_pkg::CFG_LOW_THR:  low_thr_d  = cfg_i.data[lprl_pkg::THR_W-1:0];
        lprl_pkg::CFG_HIGH_THR: high_thr_d = cfg_i.data[lprl_pkg::THR_W-1:0];
        lprl_pkg::CFG_RUN_TOL:  run_tol_d  = cfg_i.data[lprl_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= lprl_pkg::LOW_THR_RST;
      high_thr_q <= lprl_pkg::HIGH_THR_RST;
      run_tol_q  <= lprl_pkg::RUN_TOL_RST;
    end else begin
      low_thr_q  <= low_thr_d;
      high_thr_q <= high_thr_d;
      run_tol_q  <= run_tol_d;
    end
  end

  assign sample_i.ready = q_ready_i;
  assign q_push_o       = sample_i.valid && q_ready_i;
  assign q_data_o.dark  = (sample_i.adc_sample <= low_thr_q);
  assign q_data_o.lit   = (sample_i.adc_sample >= high_thr_q);
  assign run_tol_o      = run_tol_q;

endmodule

// File: rtl/lprl_fifo.sv
// Short queue of sample classes between the front and the back end.
// Depends on lprl_pkg.
module lprl_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  lprl_pkg::sample_class_t data_i,
  output logic                    ready_o,
  input  logic                    pop_i,
  output logic                    valid_o,
  output lprl_pkg::sample_class_t data_o
);

  lprl_pkg::sample_class_t mem_q [lprl_pkg::FIFO_DEPTH];
  logic [lprl_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [lprl_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [lprl_pkg::FIFO_CNT_W-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign ready_o = (count_q != lprl_pkg::FIFO_CNT_W'(lprl_pkg::FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == lprl_pkg::FIFO_PTR_W'(lprl_pkg::FIFO_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == lprl_pkg::FIFO_PTR_W'(lprl_pkg::FIFO_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/lprl_back.sv
// Back end: run counters, header references, bit gathering and the frame
// output register.
// Depends on lprl_pkg and lprl_if.
module lprl_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cls_valid_i,
  input  lprl_pkg::sample_class_t    cls_i,
  output logic                       cls_pop_o,
  input  logic [lprl_pkg::TOL_W-1:0] run_tol_i,
  lprl_frame_if.source               frame_o
);

  localparam int CW = lprl_pkg::COUNT_BITS;
  localparam int PW = lprl_pkg::POS_W;
  localparam int FL = lprl_pkg::FRAME_LEN;

  logic [CW-1:0] dark_run_q, dark_run_d, lit_run_q, lit_run_d;
  logic [CW-1:0] dark_ref_q, dark_ref_d, lit_ref_q, lit_ref_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [FL-1:0] frame_q, frame_d;
  logic          start_seen_q, start_seen_d;
  logic          lit_ref_ok_q, lit_ref_ok_d;
  logic          dark_ref_ok_q, dark_ref_ok_d;
  logic          rising_q, rising_d;
  logic          out_valid_q, out_valid_d;
  logic [FL-1:0] out_bits_q, out_bits_d;

  logic          take;
  logic [CW-1:0] dark_run1, lit_run1, run_sel, ref_sel, run_diff;
  logic          rising1, far;
  logic [1:0]    put_n;
  logic          put_v;
  logic [PW:0]   pos_next;
  logic [FL-1:0] frame_next;

  assign take      = cls_valid_i && (!out_valid_q || frame_o.ready);
  assign cls_pop_o = take;

  always_comb begin
    dark_run1 = dark_run_q;
    lit_run1  = lit_run_q;
    rising1   = rising_q;
    // The dark update comes first, so a sample in both classes ends rising.
    if (cls_i.dark) begin
      if (dark_run1 != '1) begin
        dark_run1 = dark_run1 + 1'b1;
      end
      if (lit_run_q != '0) begin
        rising1 = 1'b0;
      end
    end
    if (cls_i.lit) begin
      if (lit_run1 != '1) begin
        lit_run1 = lit_run1 + 1'b1;
      end
      if (dark_run1 != '0) begin
        rising1 = 1'b1;
      end
    end
  end

  // Distance of the ended run from its reference.
  assign run_sel  = rising1 ? dark_run1 : lit_run1;
  assign ref_sel  = rising1 ? dark_ref_q : lit_ref_q;
  assign run_diff = (run_sel >= ref_sel) ? run_sel - ref_sel : ref_sel - run_sel;
  assign far      = (run_diff >= CW'(run_tol_i));

  always_comb begin
    dark_run_d    = dark_run1;
    lit_run_d     = lit_run1;
    dark_ref_d    = dark_ref_q;
    lit_ref_d     = lit_ref_q;
    start_seen_d  = start_seen_q;
    lit_ref_ok_d  = lit_ref_ok_q;
    dark_ref_ok_d = dark_ref_ok_q;
    rising_d      = rising1;
    put_n         = 2'd0;
    put_v         = 1'b0;

    if (dark_run1 != '0 && lit_run1 != '0 && int'(pos_q) < FL) begin
      if (rising1) begin
        if (!lit_ref_ok_q && !dark_ref_ok_q) begin
          put_n        = 2'd1;
          start_seen_d = 1'b1;
        end else if (lit_ref_ok_q && !dark_ref_ok_q) begin
          put_n         = 2'd1;
          dark_ref_d    = dark_run1;
          dark_ref_ok_d = 1'b1;
          start_seen_d  = 1'b0;
        end else if (lit_ref_ok_q && dark_ref_ok_q && !start_seen_q) begin
          put_n = far ? 2'd2 : 2'd1;
        end
        dark_run_d = '0;
      end else begin
        put_v = 1'b1;
        if (start_seen_q) begin
          put_n        = 2'd1;
          lit_ref_d    = lit_run1;
          lit_ref_ok_d = 1'b1;
        end else if (lit_ref_ok_q && dark_ref_ok_q) begin
          put_n = far ? 2'd2 : 2'd1;
        end
        lit_run_d = '0;
      end
    end

    // The second bit of a double run is dropped once the frame is full.
    if (put_n == 2'd2 && int'(pos_q) + 1 >= FL) begin
      put_n = 2'd1;
    end
    pos_next = {1'b0, pos_q} + (PW + 1)'(put_n);

    frame_next = frame_q;
    for (int i = 0; i < FL; i++) begin
      if ((put_n != 2'd0 && i == int'(pos_q)) ||
          (put_n == 2'd2 && i == int'(pos_q) + 1)) begin
        frame_next[i] = put_v;
      end
    end
    frame_d = frame_next;
    pos_d   = pos_next[PW-1:0];

    out_valid_d = out_valid_q && !frame_o.ready;
    out_bits_d  = out_bits_q;
    if (int'(pos_next) >= FL) begin
      out_valid_d   = take;
      out_bits_d    = frame_next;
      dark_run_d    = '0;
      lit_run_d     = '0;
      dark_ref_d    = '0;
      lit_ref_d     = '0;
      pos_d         = '0;
      frame_d       = '0;
      start_seen_d  = 1'b0;
      lit_ref_ok_d  = 1'b0;
      dark_ref_ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_run_q    <= '0;
      lit_run_q     <= '0;
      dark_ref_q    <= '0;
      lit_ref_q     <= '0;
      pos_q         <= '0;
      frame_q       <= '0;
      start_seen_q  <= 1'b0;
      lit_ref_ok_q  <= 1'b0;
      dark_ref_ok_q <= 1'b0;
      rising_q      <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      if (take) begin
        dark_run_q    <= dark_run_d;
        lit_run_q     <= lit_run_d;
        dark_ref_q    <= dark_ref_d;
        lit_ref_q     <= lit_ref_d;
        pos_q         <= pos_d;
        frame_q       <= frame_d;
        start_seen_q  <= start_seen_d;
        lit_ref_ok_q  <= lit_ref_ok_d;
        dark_ref_ok_q <= dark_ref_ok_d;
        rising_q      <= rising_d;
      end
      out_valid_q <= take ? out_valid_d : (out_valid_q && !frame_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_bits_q <= out_bits_d;
    end
  end

  assign frame_o.valid      = out_valid_q;
  assign frame_o.frame_bits = out_bits_q;

endmodule

// File: rtl/light_pulse_run_length_decoder.sv
// Light pulse run-length decoder, top level. One ADC sample is accepted per
// clock cycle, and when nothing stalls a decoded frame is presented on the
// frame channel by the back end's output register once the sample completing
// it has left the queue. The front end compares each sample against the two
// thresholds as it is accepted and pushes the class into a two-entry queue;
// the back end takes one class per cycle from that queue into the run
// counters and the frame store. The back end holds a single output register,
// so it stops whenever a finished frame waits to be taken; the queue then
// fills up and sample ready drops once it is full. Configuration writes are
// always accepted and take effect from the next cycle.
// Depends on lprl_pkg, lprl_if, lprl_front, lprl_fifo and lprl_back.
module light_pulse_run_length_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  lprl_sample_if.sink   sample_i,
  lprl_cfg_if.sink      cfg_i,
  lprl_frame_if.source  frame_o
);

  // Classes travel from the front end to the back end through the queue.
  logic                             q_ready;
  logic                             q_push;
  lprl_pkg::sample_class_t          q_in;
  logic                             q_valid;
  logic                             q_pop;
  lprl_pkg::sample_class_t          q_out;
  logic [lprl_pkg::TOL_W-1:0]       run_tol;

  // Threshold compares and the configuration registers.
  lprl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_i),
    .cfg_i     (cfg_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_data_o  (q_in),
    .run_tol_o (run_tol)
  );

  // The queue lets the front end keep taking samples while a frame waits.
  lprl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  // Run counting, header handling, bit gathering and frame output.
  lprl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (q_valid),
    .cls_i       (q_out),
    .cls_pop_o   (q_pop),
    .run_tol_i   (run_tol),
    .frame_o     (frame_o)
  );

endmodule

// File: rtl/lprl_checker.sv
// Port-level checks for the light pulse run-length decoder, bound to the
// top level. Depends on lprl_pkg.
module lprl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_i,
  input logic                           cfg_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [lprl_pkg::FRAME_LEN-1:0] out_bits_i
);

  // A frame that is stalled stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_bits_i))
    else $error("stalled frame changed");

  // Every frame opens with the zero bit of its header.
  a_header_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !out_bits_i[0])
    else $error("frame does not start with a zero bit");

  // The sample side only backs up behind a stalled frame.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("sample ready low without a stalled frame");

  // Configuration writes never stall.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration channel not ready");

endmodule

bind light_pulse_run_length_decoder lprl_checker u_lprl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (sample_i.ready),
  .cfg_ready_i (cfg_i.ready),
  .out_valid_i (frame_o.valid),
  .out_ready_i (frame_o.ready),
  .out_bits_i  (frame_o.frame_bits)
);

// File: dv/tb_top.sv
// Self-checking testbench for the light pulse run-length decoder.
// Depends on lprl_pkg, the lprl interfaces and light_pulse_run_length_decoder.
// Frames are checked against a cycle-free predictor fed by the other channels.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lprl_pkg::*;

  localparam int unsigned SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
  // Index 3 has no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  // Two-entry class queue plus the back end's output register, with some margin.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 2000;
  localparam int unsigned RANDOM_FRAMES = 40;
  localparam int unsigned PHASE_ITEMS   = 250;
  localparam int unsigned MAX_PHASES    = 24;

  typedef enum logic [1:0] {
    RUN_DARK,
    RUN_LIT,
    RUN_DEAD
  } level_e;

  // Frame predictor and scoreboard. The decoder state is mirrored here and
  // advanced once per accepted sample transaction; any completed frame is
  // queued and later compared against the frame channel.
  class frame_scoreboard;
    logic [THR_W-1:0]      dark_limit;
    logic [THR_W-1:0]      lit_limit;
    logic [TOL_W-1:0]      tolerance;
    logic [COUNT_BITS-1:0] dark_len;
    logic [COUNT_BITS-1:0] lit_len;
    logic [COUNT_BITS-1:0] dark_ref_len;
    logic [COUNT_BITS-1:0] lit_ref_len;
    int unsigned           nbits;
    logic [FRAME_LEN-1:0]  bits;
    bit                    header_open;
    bit                    lit_ref_ok;
    bit                    dark_ref_ok;
    bit                    rising;
    logic [FRAME_LEN-1:0]  frames_due[$];
    int unsigned           n_errors;
    int unsigned           n_frames_predicted;

    function new();
      dark_limit = LOW_THR_RST;
      lit_limit  = HIGH_THR_RST;
      tolerance  = RUN_TOL_RST;
      restart_decoder();
      rising             = 1'b1;
      n_errors           = 0;
      n_frames_predicted = 0;
    endfunction

    // Everything but the edge direction goes back to its reset value.
    function void restart_decoder();
      dark_len     = '0;
      lit_len      = '0;
      dark_ref_len = '0;
      lit_ref_len  = '0;
      nbits        = 0;
      bits         = '0;
      header_open  = 1'b0;
      lit_ref_ok   = 1'b0;
      dark_ref_ok  = 1'b0;
    endfunction

    function void take_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LOW_THR:  dark_limit = data[THR_W-1:0];
        CFG_HIGH_THR: lit_limit  = data[THR_W-1:0];
        CFG_RUN_TOL:  tolerance  = data[TOL_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_bit(bit v);
      if (nbits < FRAME_LEN) begin
        bits[nbits] = v;
        nbits++;
      end
    endfunction

    function bit is_far(logic [COUNT_BITS-1:0] run, logic [COUNT_BITS-1:0] refl);
      logic [COUNT_BITS-1:0] diff;
      diff = (run >= refl) ? run - refl : refl - run;
      return diff >= tolerance;
    endfunction

    // A run far from its reference stands for two like bits, the second of
    // which is lost when the frame is already full.
    function void push_run(bit v, bit twice);
      push_bit(v);
      if (twice && nbits < FRAME_LEN)
        push_bit(v);
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      sample_class_t cls;
      cls.dark = (s <= dark_limit);
      cls.lit  = (s >= lit_limit);
      // With overlapping thresholds the dark update goes first, so the lit
      // update decides the edge direction.
      if (cls.dark) begin
        if (dark_len != {COUNT_BITS{1'b1}})
          dark_len++;
        if (lit_len != '0)
          rising = 1'b0;
      end
      if (cls.lit) begin
        if (lit_len != {COUNT_BITS{1'b1}})
          lit_len++;
        if (dark_len != '0)
          rising = 1'b1;
      end
      if (dark_len != '0 && lit_len != '0 && nbits < FRAME_LEN) begin
        if (rising) begin
          if (!lit_ref_ok && !dark_ref_ok) begin
            push_bit(1'b0);
            header_open = 1'b1;
          end else if (lit_ref_ok && !dark_ref_ok) begin
            push_bit(1'b0);
            dark_ref_len = dark_len;
            dark_ref_ok  = 1'b1;
            header_open  = 1'b0;
          end else if (lit_ref_ok && dark_ref_ok && !header_open) begin
            push_run(1'b0, is_far(dark_len, dark_ref_len));
          end
          dark_len = '0;
        end else begin
          if (header_open) begin
            push_bit(1'b1);
            lit_ref_len = lit_len;
            lit_ref_ok  = 1'b1;
          end else if (lit_ref_ok && dark_ref_ok) begin
            push_run(1'b1, is_far(lit_len, lit_ref_len));
          end
          lit_len = '0;
        end
      end
      if (nbits >= FRAME_LEN) begin
        frames_due.push_back(bits);
        n_frames_predicted++;
        restart_decoder();
      end
    endfunction

    task report_mismatch(string what);
      n_errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_frame(logic [FRAME_LEN-1:0] got);
      logic [FRAME_LEN-1:0] want;
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("frame %03h arrived with none expected", got));
      end else begin
        want = frames_due.pop_front();
        if (got !== want)
          report_mismatch($sformatf("frame_bits %03h, expected %03h", got, want));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  lprl_sample_if sample_bus ();
  lprl_cfg_if    cfg_bus ();
  lprl_frame_if  frame_bus ();

  light_pulse_run_length_decoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_bus),
    .cfg_i    (cfg_bus),
    .frame_o  (frame_bus)
  );

  frame_scoreboard sb = new();

  // Thresholds as last written, used only to shape the stimulus.
  int unsigned cur_low;
  int unsigned cur_high;
  int unsigned cur_tol;
  int unsigned samples_sent;
  // While set, neither side inserts gaps.
  bit calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // All three channels are observed at the clock edge, where a transaction
  // is defined by valid and ready both being high.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready)
        sb.take_config(cfg_bus.index, cfg_bus.data);
      if (frame_bus.valid && frame_bus.ready)
        sb.check_frame(frame_bus.frame_bits);
      if (sample_bus.valid && sample_bus.ready)
        sb.note_sample(sample_bus.adc_sample);
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // The frame sink holds ready high for a while and then may stall.
  initial begin : frame_sink
    int unsigned hold;
    int unsigned pause;
    frame_bus.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      hold = $urandom_range(12, 1);
      frame_bus.ready <= 1'b1;
      repeat (hold) @(posedge clk_i);
      pause = pick_gap();
      if (pause != 0) begin
        frame_bus.ready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
    end
  end

  // Valid is left high on return so that a back-to-back sample never needs
  // a second assignment to it in the same time step.
  task automatic send_sample(logic [SAMPLE_W-1:0] v, bit nogap);
    int unsigned gap;
    gap = nogap ? 0 : pick_gap();
    if (gap != 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_bus.valid      <= 1'b1;
    sample_bus.adc_sample <= v;
    @(posedge clk_i);
    while (!sample_bus.ready) @(posedge clk_i);
    samples_sent++;
  endtask

  task automatic drive_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
  endtask

  // Waits until every predicted frame has been taken, then lets any sample
  // still queued inside the block drain before the registers change.
  task automatic settle_block();
    sample_bus.valid <= 1'b0;
    while (sb.frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(int unsigned lo, int unsigned hi, int unsigned tol);
    settle_block();
    cur_low  = lo;
    cur_high = hi;
    cur_tol  = tol;
    drive_config(CFG_LOW_THR, CFG_DATA_W'(lo));
    drive_config(CFG_HIGH_THR, CFG_DATA_W'(hi));
    // The upper data bits of a tolerance write must be ignored.
    drive_config(CFG_RUN_TOL, {4'($urandom_range(15)), 8'(tol)});
    if ($urandom_range(3) == 0)
      drive_config(CFG_SPARE_IDX, CFG_DATA_W'($urandom_range(SAMPLE_MAX)));
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_level(level_e lvl);
    case (lvl)
      RUN_DARK: return SAMPLE_W'($urandom_range(cur_low, 0));
      RUN_LIT:  return SAMPLE_W'($urandom_range(SAMPLE_MAX, cur_high));
      default:  return SAMPLE_W'($urandom_range(cur_high - 1, cur_low + 1));
    endcase
  endfunction

  // Dead-zone samples are sprinkled into runs; they must not lengthen them.
  task automatic send_run(level_e lvl, int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if (cur_high > cur_low + 1 && $urandom_range(7) == 0)
        send_sample(pick_level(RUN_DEAD), 1'b0);
      send_sample(pick_level(lvl), 1'b0);
    end
  endtask

  // The first three runs of a burst set up the header references; later
  // runs sit within the tolerance of them, or clearly outside it.
  function automatic int unsigned vary_len(int unsigned base, int unsigned k);
    int unsigned jitter;
    if (k < 3)
      return base;
    case ($urandom_range(3))
      0: return base;
      1: begin
        jitter = (cur_tol > 4) ? 3 : ((cur_tol > 0) ? cur_tol - 1 : 0);
        return base + $urandom_range(jitter);
      end
      2: return base + ((cur_tol <= 48) ? cur_tol : 0) + $urandom_range(3);
      default: return (base > cur_tol + 1) ? $urandom_range(base - cur_tol, 1) : base;
    endcase
  endfunction

  // One burst is either noise or a train of alternating runs, which may be
  // cut short to leave the decoder part way through a header.
  task automatic send_burst();
    int unsigned roll;
    int unsigned dark_base;
    int unsigned lit_base;
    int unsigned nruns;
    int unsigned k;
    roll = $urandom_range(99);
    calm = ($urandom_range(9) < 2);
    if (roll < 12) begin
      repeat ($urandom_range(24, 1))
        send_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX)), 1'b0);
    end else begin
      dark_base = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
      lit_base  = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
      nruns     = (roll < 20) ? $urandom_range(4, 1) : $urandom_range(18, 6);
      for (k = 0; k < nruns; k++) begin
        if (k % 2 == 0)
          send_run(RUN_DARK, vary_len(dark_base, k));
        else
          send_run(RUN_LIT, vary_len(lit_base, k));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned k;
    int unsigned phase;
    int unsigned item_base;
    int unsigned frame_base;
    int unsigned phase_base;
    int unsigned lo;
    int unsigned hi;
    int unsigned tol;
    int unsigned set_lo[6]  = '{117, 0, 4095, 1000, 2000, 400};
    int unsigned set_hi[6]  = '{651, 4095, 0, 1100, 1500, 3000};
    int unsigned set_tol[6] = '{15, 0, 255, 1, 7, 40};

    rst_ni                = 1'b0;
    sample_bus.valid      = 1'b0;
    sample_bus.adc_sample = '0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = CFG_LOW_THR;
    cfg_bus.data          = '0;
    cur_low               = LOW_THR_RST;
    cur_high              = HIGH_THR_RST;
    cur_tol               = RUN_TOL_RST;
    samples_sent          = 0;
    calm                  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset thresholds: a lit run before any dark one is dropped on its
    // falling edge, then the header is built and the first data bit follows.
    // Both sample extremes, the threshold boundaries and the dead zone appear.
    send_sample(12'd4095, 1'b0);
    send_sample(12'd0, 1'b0);
    send_sample(12'd118, 1'b0);
    send_sample(12'd651, 1'b0);
    send_sample(12'd117, 1'b0);
    send_sample(12'd650, 1'b0);
    send_sample(12'd700, 1'b0);
    send_sample(12'd2048, 1'b0);
    send_sample(12'd0, 1'b0);

    // With zero tolerance every data run is a double bit, so the second
    // frame ends on a double bit whose second half has no room left.
    apply_setting(LOW_THR_RST, HIGH_THR_RST, 0);
    for (k = 0; k < 14; k++)
      send_sample((k % 2 == 0) ? SAMPLE_W'(SAMPLE_MAX - k) : SAMPLE_W'(k), 1'b0);

    // Overlapping thresholds: samples between them count as dark and lit at
    // once and are taken as a rising edge.
    apply_setting(1000, 500, 0);
    send_sample(12'd700, 1'b0);
    send_sample(12'd700, 1'b0);
    send_sample(12'd200, 1'b0);
    send_sample(12'd3000, 1'b0);
    send_sample(12'd700, 1'b0);

    // Random part: a few fixed corner settings first, random ones after.
    item_base  = samples_sent;
    frame_base = sb.n_frames_predicted;
    phase      = 0;
    while (phase < MAX_PHASES && (samples_sent - item_base < RANDOM_ITEMS ||
           sb.n_frames_predicted - frame_base < RANDOM_FRAMES)) begin
      if (phase < 6) begin
        lo  = set_lo[phase];
        hi  = set_hi[phase];
        tol = set_tol[phase];
      end else begin
        lo  = $urandom_range(3000);
        hi  = lo + $urandom_range(1000, 2);
        if (hi > SAMPLE_MAX)
          hi = SAMPLE_MAX;
        tol = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(20);
      end
      apply_setting(lo, hi, tol);
      phase_base = samples_sent;
      while (samples_sent - phase_base < PHASE_ITEMS)
        send_burst();
      phase++;
    end

    calm = 1'b0;
    settle_block();
    if (sb.n_errors == 0) begin
      $display("** light_pulse_run_length_decoder: PASSED **");
    end else begin
      $display("** light_pulse_run_length_decoder: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("** light_pulse_run_length_decoder: FAILED **");
    $finish;
  end

endmodule
